// ===== sv/id_allocator_free_stack_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ID_ALLOCATOR_FREE_STACK_MACROS_SVH
`define ID_ALLOCATOR_FREE_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/id_afs_pkg.sv =====
package id_afs_pkg;

	localparam int ID_W        = 10;
	localparam int CMD_W       = 2;
	localparam int ST_W        = 3;
	localparam int MAX_IDS_DEF = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_NEW    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_CLAIM  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_CLAIM_BELOW = 3'd1,
		ST_NOT_LISTED  = 3'd2,
		ST_EXHAUSTED   = 3'd3,
		ST_RANGE       = 3'd4,
		ST_FULL        = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_SCAN
	} state_t;

	// per-cycle move of the cell row
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t        op;
		logic [ID_W-1:0] data;
	} cell_ctl_t;

endpackage

// ===== sv/id_allocator_free_stack.sv =====
// Channel   | Signals                       | Beat taken when
// ----------+-------------------------------+----------------------------------
// command   | start, busy, command, id_value| rising edge with start & !busy
// result    | done, id_out, status          | the one cycle done is high
//
// New, delete, clear, claim at the mark or into an empty stack below it, and
// out-of-range or full cases: result strobed in the cycle after the beat;
// busy stays low, so a command may follow every cycle.
// Claim above the mark: one ID pushed into the cell row per cycle while
// busy. Claim below the mark into a non-empty stack: the stack rotating
// once through the top cell to drop the first copy.
// Reset clears the count, mark and control; the stack cells need no clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
module id_allocator_free_stack import id_afs_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] command,
	input  logic [ID_W-1:0]  id_value,
	output logic             done,
	output logic [ID_W-1:0]  id_out,
	output logic [ST_W-1:0]  status
);

	// count and mark both reach MAX_IDS itself
	localparam int CW = $clog2(MAX_IDS + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   mark_q, mark_d;
	logic [CW-1:0]   walk_q, walk_d;
	logic            found_q, found_d;
	logic [ID_W-1:0] key_q, key_d;
	logic            done_q, done_d;
	logic [ID_W-1:0] id_out_q, id_out_d;
	status_t         status_q, status_d;

	cell_ctl_t       ctl;
	logic [ID_W-1:0] head;

	logic            accept;
	logic            in_range;
	logic [CW-1:0]   id_c;
	logic [CW:0]     need;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start & ~busy;
	assign in_range = (32'(id_value) < 32'(MAX_IDS));
	// only used once in_range holds, so the cast loses nothing
	assign id_c     = CW'(id_value);
	// stack depth after a fill from the mark up to id-1
	assign need     = {1'b0, count_q} + ({1'b0, id_c} - {1'b0, mark_q});

	id_afs_chain #(
		.DEPTH (MAX_IDS),
		.CW    (CW)
	) u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.count (count_q),
		.head  (head)
	);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		mark_d   = mark_q;
		walk_d   = walk_q;
		found_d  = found_q;
		key_d    = key_q;
		done_d   = 1'b0;
		id_out_d = '0;
		status_d = ST_OK;
		ctl.op   = OP_HOLD;
		ctl.data = head;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (cmd_t'(command))
						CMD_NEW: begin
							if (count_q != '0) begin
								// reuse the most recently freed ID
								ctl.op   = OP_POP;
								count_d  = count_q - CW'(1);
								id_out_d = head;
							end else if (mark_q != CW'(MAX_IDS)) begin
								id_out_d = ID_W'(mark_q);
								mark_d   = mark_q + CW'(1);
							end else begin
								status_d = ST_EXHAUSTED;
							end
						end
						CMD_DELETE: begin
							if (!in_range) begin
								status_d = ST_RANGE;
							end else if (id_c >= mark_q) begin
								status_d = ST_NOT_LISTED;
							end else if (({1'b0, id_c} + (CW+1)'(1)) == {1'b0, mark_q}) begin
								// top of the issued range: give it back to the mark
								mark_d   = mark_q - CW'(1);
								status_d = ST_NOT_LISTED;
							end else if (count_q == CW'(MAX_IDS)) begin
								status_d = ST_FULL;
							end else begin
								ctl.op   = OP_PUSH;
								ctl.data = id_value;
								count_d  = count_q + CW'(1);
							end
						end
						CMD_CLAIM: begin
							if (!in_range) begin
								status_d = ST_RANGE;
							end else if (id_c < mark_q) begin
								status_d = ST_CLAIM_BELOW;
								if (count_q != '0) begin
									done_d  = 1'b0;
									key_d   = id_value;
									walk_d  = count_q;
									found_d = 1'b0;
									state_d = S_SCAN;
								end
							end else if (need > (CW+1)'(MAX_IDS)) begin
								status_d = ST_FULL;
							end else if (id_c == mark_q) begin
								mark_d   = mark_q + CW'(1);
								id_out_d = id_value;
							end else begin
								done_d  = 1'b0;
								key_d   = id_value;
								state_d = S_FILL;
							end
						end
						CMD_CLEAR: begin
							count_d = '0;
						end
						default: ;
					endcase
				end
			end
			S_FILL: begin
				// push the skipped IDs in rising order, one a cycle
				ctl.op   = OP_PUSH;
				ctl.data = ID_W'(mark_q);
				count_d  = count_q + CW'(1);
				mark_d   = mark_q + CW'(1);
				if ((mark_q + CW'(1)) == CW'(key_q)) begin
					mark_d   = CW'(key_q) + CW'(1);
					id_out_d = key_q;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// each cycle the top entry is dropped (first match) or wrapped to the tail
				if (!found_q && (head == key_q)) begin
					ctl.op  = OP_POP;
					count_d = count_q - CW'(1);
					found_d = 1'b1;
				end else begin
					ctl.op   = OP_ROTATE;
					ctl.data = head;
				end
				walk_d = walk_q - CW'(1);
				if (walk_q == CW'(1)) begin
					status_d = ST_CLAIM_BELOW;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mark_q  <= '0;
			walk_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			mark_q  <= mark_d;
			walk_q  <= walk_d;
			found_q <= found_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		id_out_q <= id_out_d;
		status_q <= status_d;
	end

	assign done   = done_q;
	assign id_out = id_out_q;
	assign status = status_q;

endmodule

// ===== sv/id_afs_cell.sv =====
module id_afs_cell import id_afs_pkg::*; (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic [ID_W-1:0] up_val,
	input  logic [ID_W-1:0] dn_val,
	input  logic            is_tail,
	output logic [ID_W-1:0] val
);

	logic [ID_W-1:0] val_q;

	// push: take from above; pop: take from below; rotate: tail takes the old top
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH:   val_q <= up_val;
			OP_POP:    val_q <= dn_val;
			OP_ROTATE: val_q <= is_tail ? ctl.data : dn_val;
			default:   val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ===== sv/id_afs_chain.sv =====
module id_afs_chain import id_afs_pkg::*; #(
	parameter int DEPTH = MAX_IDS_DEF,
	parameter int CW    = $clog2(MAX_IDS_DEF + 1)
) (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic [CW-1:0]   count,
	output logic [ID_W-1:0] head
);

	logic [ID_W-1:0] vals [DEPTH];

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [ID_W-1:0] up_v;
		logic [ID_W-1:0] dn_v;

		if (j == 0) begin : g_top
			assign up_v = ctl.data;
		end else begin : g_mid_up
			assign up_v = vals[j-1];
		end

		if (j == DEPTH - 1) begin : g_bot
			assign dn_v = ctl.data;
		end else begin : g_mid_dn
			assign dn_v = vals[j+1];
		end

		id_afs_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.up_val  (up_v),
			.dn_val  (dn_v),
			.is_tail (count == CW'(j + 1)),
			.val     (vals[j])
		);
	end

	assign head = vals[0];

endmodule

// ===== sv/id_afs_checker.sv =====
`include "id_allocator_free_stack_macros.svh"

module id_afs_checker import id_afs_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input logic [ID_W-1:0] id_out,
	input logic [ST_W-1:0] status
);

	// a taken command either answers at once or holds busy
	`AFS_ASSERT_NEXT(a_accept_reply, clk, arst_n, start && !busy, done || busy, "command beat lost")

	// a long command ends with its result
	`AFS_ASSERT_NOW(a_end_result, clk, arst_n, $fell(busy), done, "busy dropped without a result")

	// no result while a long command is still at work
	`AFS_ASSERT_NOW(a_busy_quiet, clk, arst_n, busy, !done, "result strobed while busy")

	// every failing status carries a zero ID
	`AFS_ASSERT_NOW(a_err_zero, clk, arst_n, done && (status == ST_CLAIM_BELOW || status == ST_NOT_LISTED || status == ST_EXHAUSTED || status == ST_RANGE || status == ST_FULL), id_out == '0, "error result with non-zero ID")

endmodule

bind id_allocator_free_stack id_afs_checker u_afs_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import id_afs_pkg::*;

	// Worst honest run: about 650 commands, each a claim that walks a full
	// stack behind a long sender gap. A few times that.
	localparam int CYCLE_LIMIT = 4_000_000;
	// Longest single command: a claim that rotates a full stack.
	localparam int DRAIN_CYCLES = MAX_IDS_DEF + 64;

	typedef struct packed {
		logic [ID_W-1:0] id;
		status_t         st;
	} grant_t;

	// Mirror of the allocator: its own free stack and fresh mark, plus the
	// grants still owed by the block, oldest first.
	class id_ledger;
		logic [ID_W-1:0] free_ids[$];
		int unsigned     mark;
		grant_t          expected_grants[$];
		int              errors;
		int              checked;
		int              deepest;
		int              cmd_seen[4];

		function new();
			mark    = 0;
			errors  = 0;
			checked = 0;
			deepest = 0;
			foreach (cmd_seen[n])
				cmd_seen[n] = 0;
		endfunction

		// One accepted command beat: update the mirror, queue the grant.
		function void note_command(cmd_t cmd, logic [ID_W-1:0] id_raw);
			grant_t g;
			int     id;
			int     k;
			int     i;
			id   = int'(id_raw);
			g.id = '0;
			g.st = ST_OK;
			cmd_seen[int'(cmd)]++;
			case (cmd)
				CMD_NEW: begin
					if (free_ids.size() > 0) begin
						g.id = free_ids.pop_back();
					end else if (mark < MAX_IDS_DEF) begin
						g.id = mark[ID_W-1:0];
						mark++;
					end else begin
						g.st = ST_EXHAUSTED;
					end
				end
				CMD_DELETE: begin
					if (id >= MAX_IDS_DEF) begin
						g.st = ST_RANGE;
					end else if (id >= mark) begin
						g.st = ST_NOT_LISTED;
					end else if (id + 1 == mark) begin
						// just below the mark: give it back to the fresh range
						mark--;
						g.st = ST_NOT_LISTED;
					end else if (free_ids.size() >= MAX_IDS_DEF) begin
						g.st = ST_FULL;
					end else begin
						free_ids.push_back(id_raw);
					end
				end
				CMD_CLAIM: begin
					if (id >= MAX_IDS_DEF) begin
						g.st = ST_RANGE;
					end else if (id < mark) begin
						// drop the copy nearest the top, keep the rest in order
						for (k = free_ids.size() - 1; k >= 0; k--) begin
							if (free_ids[k] == id_raw) begin
								free_ids.delete(k);
								break;
							end
						end
						g.st = ST_CLAIM_BELOW;
					end else if (free_ids.size() + (id - mark) > MAX_IDS_DEF) begin
						g.st = ST_FULL;
					end else begin
						for (i = mark; i < id; i++)
							free_ids.push_back(i[ID_W-1:0]);
						mark = id + 1;
						g.id = id_raw;
					end
				end
				default: begin
					free_ids.delete();
				end
			endcase
			if (free_ids.size() > deepest)
				deepest = free_ids.size();
			expected_grants.push_back(g);
		endfunction

		function void check_result(logic [ID_W-1:0] got_id, logic [ST_W-1:0] got_st);
			grant_t g;
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result beat, id_out %0d status %0d",
					$time, got_id, got_st);
				errors++;
				return;
			end
			g = expected_grants.pop_front();
			checked++;
			if (got_id !== g.id) begin
				$display("%0t: id_out mismatch, expected %0d, actual %0d",
					$time, g.id, got_id);
				errors++;
			end
			if (got_st !== g.st) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, g.st, got_st);
				errors++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	cmd_t            command = CMD_NEW;
	logic [ID_W-1:0] id_value = '0;
	logic            done;
	logic [ID_W-1:0] id_out;
	logic [ST_W-1:0] status;

	id_ledger ledger = new();
	int       idle_pct = 0;
	int       cycle_count = 0;

	id_allocator_free_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.id_value (id_value),
		.done     (done),
		.id_out   (id_out),
		.status   (status)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding",
				$time, ledger.expected_grants.size());
			$display("id_allocator_free_stack test failed");
			$finish;
		end
	end

	// Results are sampled mid-cycle, well away from the edges that move them.
	always @(negedge clk) begin
		if (arst_n && done)
			ledger.check_result(id_out, status);
	end

	// One command beat. Start stays high on return, so back-to-back beats
	// never lower and raise it in the same step; it only drops for a gap.
	// Busy is looked at on the falling edge, where it is settled.
	task automatic send(cmd_t cmd, logic [ID_W-1:0] id);
		bit taken;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start    <= 1'b1;
		command  <= cmd;
		id_value <= id;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		ledger.note_command(cmd, id);
	endtask

	// Random commands, steered by the mirror so that most deletes hit IDs below
	// the mark and most claims hit listed IDs, the mark or just above it; the rest is noise.
	task automatic run_random(int count, int pct);
		cmd_t cmd;
		int   id;
		int   pick;
		int   depth;
		idle_pct = pct;
		repeat (count) begin
			depth = ledger.free_ids.size();
			pick  = $urandom_range(99);
			id    = $urandom_range(1023);
			if (pick < 30) begin
				cmd = CMD_NEW;
			end else if (pick < 65) begin
				cmd  = CMD_DELETE;
				pick = $urandom_range(9);
				if (pick < 4 && ledger.mark > 0)
					id = ledger.mark - 1;
				else if (pick < 7 && ledger.mark > 1)
					id = $urandom_range(ledger.mark - 2);
			end else if (pick < 94) begin
				cmd  = CMD_CLAIM;
				pick = $urandom_range(9);
				if (pick < 4 && ledger.mark < MAX_IDS_DEF) begin
					id = ledger.mark + $urandom_range(6);
					if (id > 1023)
						id = 1023;
				end else if (pick < 8 && depth > 0) begin
					id = ledger.free_ids[$urandom_range(depth - 1)];
				end else if (pick < 9 && ledger.mark > 0) begin
					id = $urandom_range(ledger.mark - 1);
				end
			end else begin
				cmd = CMD_CLEAR;
			end
			send(cmd, id[ID_W-1:0]);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, from reset: fresh issue, mark drop, ignored deletes,
		// claims at, above and below the mark, duplicates, clear.
		idle_pct = 28;
		send(CMD_NEW, '0);
		send(CMD_NEW, '1);            // id field ignored for new
		send(CMD_DELETE, 10'd1);      // just below the mark
		send(CMD_DELETE, 10'd1);      // at the mark: ignored
		send(CMD_DELETE, 10'd900);    // past the mark: ignored
		send(CMD_CLAIM, 10'd1);       // at the mark, nothing skipped
		send(CMD_CLAIM, 10'd6);       // skips 2..5 onto the stack
		send(CMD_DELETE, 10'd0);
		send(CMD_DELETE, 10'd3);      // duplicate copy
		send(CMD_CLAIM, 10'd3);       // top copy goes
		send(CMD_CLAIM, 10'd3);       // copy from the middle goes
		send(CMD_CLAIM, 10'd3);       // no copy left
		send(CMD_NEW, '0);
		send(CMD_CLEAR, '0);
		send(CMD_NEW, '0);
		send(CMD_CLEAR, '1);          // clear of an empty stack

		// Edges: fill the stack to the brim, overflow both ways, claim into
		// exactly full, then run the fresh range dry. The mark is still low
		// here, so the first claim does nearly all of the filling.
		send(CMD_CLEAR, '0);
		if (ledger.mark < MAX_IDS_DEF)
			send(CMD_CLAIM, 10'd1023);
		while (ledger.free_ids.size() < MAX_IDS_DEF)
			send(CMD_DELETE, 10'($urandom_range(1021)));
		send(CMD_DELETE, 10'($urandom_range(1021)));   // stack full
		send(CMD_DELETE, 10'd1023);
		send(CMD_DELETE, 10'd1022);
		send(CMD_CLAIM, 10'd1023);    // would overflow
		send(CMD_CLAIM, 10'd1022);    // at the mark, stack stays exactly full
		send(CMD_CLAIM, 10'd0);       // walks the whole stack
		send(CMD_NEW, '0);
		send(CMD_CLEAR, '0);
		send(CMD_NEW, '0);            // last fresh ID
		send(CMD_NEW, '0);            // exhausted
		send(CMD_DELETE, 10'd1023);
		send(CMD_DELETE, 10'd1023);
		send(CMD_DELETE, 10'd5);
		send(CMD_NEW, '0);
		send(CMD_NEW, '0);
		send(CMD_NEW, '1);            // exhausted again

		run_random(200, 28);
		run_random(200, 86);
		run_random(200, 0);
		start <= 1'b0;

		while (ledger.expected_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands: new %0d, delete %0d, claim %0d, clear %0d; %0d results checked.",
			ledger.cmd_seen[0] + ledger.cmd_seen[1] + ledger.cmd_seen[2] + ledger.cmd_seen[3],
			ledger.cmd_seen[0], ledger.cmd_seen[1], ledger.cmd_seen[2], ledger.cmd_seen[3],
			ledger.checked);
		$display("Free stack peaked at %0d entries; %0d errors seen.",
			ledger.deepest, ledger.errors);
		if (ledger.errors == 0)
			$display("id_allocator_free_stack test passed");
		else
			$display("id_allocator_free_stack test failed");
		$finish;
	end

endmodule
